### hdl/mss_pkg.sv
// mss_pkg: shared types, command codes and constants of the sequencer track
// no dependencies
`default_nettype none
package mss_pkg;

  localparam int NOTE_SLOTS = 4;
  localparam int MAX_STEPS  = 64;
  localparam int NOTE_RANGE = 128;
  localparam int STEP_W     = $clog2(MAX_STEPS);
  localparam int SLOT_W     = 2;
  localparam int NOTE_W     = 7;
  localparam int SLOTMEM_W  = STEP_W + SLOT_W;

  localparam logic [2:0] CMD_TICK   = 3'd0;
  localparam logic [2:0] CMD_PLAY   = 3'd1;
  localparam logic [2:0] CMD_ADD    = 3'd2;
  localparam logic [2:0] CMD_CLEAR  = 3'd3;
  localparam logic [2:0] CMD_LOCK   = 3'd4;
  localparam logic [2:0] CMD_PARAMS = 3'd5;

  localparam logic [1:0] EV_OFF  = 2'd0;
  localparam logic [1:0] EV_ON   = 2'd1;
  localparam logic [1:0] EV_RETR = 2'd2;

  localparam logic REG_CHANNEL = 1'b0;
  localparam logic REG_STEPS   = 1'b1;

  localparam logic [6:0] VEL_RESET = 7'd99;
  localparam logic [3:0] LEN_RESET = 4'd1;
  localparam logic [6:0] STEPS_RESET = 7'd16;

  typedef struct packed {
    logic [2:0] cmd;
    logic [5:0] step_index;
    logic [6:0] note_number;
    logic [6:0] step_velocity_in;
    logic [3:0] step_length_in;
    logic       play_request;
    logic       on_boundary;
  } req_t;

  typedef struct packed {
    logic [1:0] event_kind;
    logic [6:0] event_note;
    logic [6:0] event_velocity;
    logic [3:0] event_channel;
    logic       last_event;
  } evt_t;

endpackage
`default_nettype wire

### hdl/mss_ram.sv
// mss_ram: generic single-port-write, single-port-read ram, registered read
// no dependencies
`default_nettype none
module mss_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

### hdl/midi_step_sequencer_track.sv
// midi_step_sequencer_track: top level of one sequencer track
// depends on mss_pkg and mss_ram
`default_nettype none
// usage
//   a request is offered on start/req while busy is low and taken at that
//   edge; if work follows, busy rises on the next cycle and falls when done
//   results appear on evt with evt_valid high for one cycle each, in order;
//   the receiver cannot stall, so the block never waits on it
//   cfg_we/cfg_index/cfg_data write midi_channel (0) and step_count (1)
// work per request
//   a tick on a boundary sweeps all 128 note timers through the timer ram,
//   each read, then written back, and then, while playing, up to four
//   slots of the current step; add and clear work on the slots of one step;
//   lock, step params, a plain tick and set playing are done on acceptance
//   and leave busy low
// reset
//   right after reset a clearing pass walks the slot ram and the timer ram,
//   and writes velocity 99, length 1 and unlocked into the step rams; busy
//   stays high during it
// storage
//   the note timers, note slots, velocity, length and lock of each step live
//   in synchronous rams with a registered read
module midi_step_sequencer_track
  import mss_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       start,
  input  wire req_t       req,
  output logic            busy,
  output logic            evt_valid,
  output evt_t            evt,
  input  wire logic       cfg_we,
  input  wire logic [0:0] cfg_index,
  input  wire logic [6:0] cfg_data
);

  localparam logic [3:0] S_INIT  = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_TRD   = 4'd2;  // timer read issued
  localparam logic [3:0] S_TWR   = 4'd3;  // timer data back, write
  localparam logic [3:0] S_SRD   = 4'd4;  // slot read issued
  localparam logic [3:0] S_SNT   = 4'd5;  // slot back, issue timer read
  localparam logic [3:0] S_SWR   = 4'd6;  // timer back, emit and reload
  localparam logic [3:0] S_ARD   = 4'd7;  // add: slot/lock read issued
  localparam logic [3:0] S_AEV   = 4'd8;  // add: evaluate slot
  localparam logic [3:0] S_CLR   = 4'd9;  // clear slots sweep
  localparam logic [3:0] S_LAST  = 4'd10; // flush pending event

  logic [3:0] state;
  logic [7:0] cnt;          // init sweep and note walk counter
  logic [1:0] slot;
  req_t       cur;
  logic [3:0] channel;
  logic [6:0] step_count;
  logic [5:0] play_pos;
  logic       playing;

  // one event held back so the last one can be marked
  logic       pend_valid;
  evt_t       pend;

  // timer ram
  logic       t_we;
  logic [6:0] t_waddr, t_raddr;
  logic [3:0] t_wdata, t_rdata;
  // slot ram
  logic                 s_we;
  logic [SLOTMEM_W-1:0] s_waddr, s_raddr;
  logic [6:0]           s_wdata, s_rdata;
  // step parameter rams: velocity, length, lock
  logic       v_we, l_we, k_we;
  logic [5:0] p_waddr, p_raddr;
  logic [6:0] v_wdata, v_rdata;
  logic [3:0] l_wdata, l_rdata;
  logic       k_wdata, k_rdata;

  mss_ram #(.WIDTH(4), .DEPTH(NOTE_RANGE)) u_timer (
    .clk, .we(t_we), .waddr(t_waddr), .wdata(t_wdata), .raddr(t_raddr), .rdata(t_rdata));
  mss_ram #(.WIDTH(7), .DEPTH(MAX_STEPS*NOTE_SLOTS)) u_slot (
    .clk, .we(s_we), .waddr(s_waddr), .wdata(s_wdata), .raddr(s_raddr), .rdata(s_rdata));
  mss_ram #(.WIDTH(7), .DEPTH(MAX_STEPS)) u_vel (
    .clk, .we(v_we), .waddr(p_waddr), .wdata(v_wdata), .raddr(p_raddr), .rdata(v_rdata));
  mss_ram #(.WIDTH(4), .DEPTH(MAX_STEPS)) u_len (
    .clk, .we(l_we), .waddr(p_waddr), .wdata(l_wdata), .raddr(p_raddr), .rdata(l_rdata));
  mss_ram #(.WIDTH(1), .DEPTH(MAX_STEPS)) u_lock (
    .clk, .we(k_we), .waddr(p_waddr), .wdata(k_wdata), .raddr(p_raddr), .rdata(k_rdata));

  logic       accept;
  logic [5:0] edit_step;
  logic [6:0] slot_note;
  logic [3:0] t_dec;
  logic [5:0] pos_inc;
  evt_t       new_evt;
  logic       new_valid;

  assign accept    = start && !busy;
  assign busy      = (state != S_IDLE);
  assign edit_step = cur.step_index;
  assign slot_note = s_rdata;
  assign t_dec     = t_rdata - 4'd1;
  // 6-bit playhead wraps on its own at 64
  assign pos_inc   = play_pos + 6'd1;

  // combinational ram control and event creation
  always_comb begin
    t_we = 1'b0; t_waddr = cnt[6:0]; t_wdata = '0; t_raddr = cnt[6:0];
    s_we = 1'b0; s_waddr = {edit_step, slot}; s_wdata = '0; s_raddr = {edit_step, slot};
    v_we = 1'b0; l_we = 1'b0; k_we = 1'b0;
    p_waddr = edit_step; p_raddr = edit_step;
    v_wdata = cur.step_velocity_in;
    l_wdata = (cur.step_length_in == 4'd0) ? 4'd1 : cur.step_length_in;
    k_wdata = 1'b0;
    new_valid = 1'b0;
    new_evt = '{event_kind: EV_OFF, event_note: cnt[6:0], event_velocity: 7'd0,
                event_channel: channel, last_event: 1'b0};
    unique case (state)
      S_INIT: begin
        t_we = 1'b1; t_waddr = cnt[6:0];
        s_we = 1'b1; s_waddr = cnt;
        p_waddr = cnt[5:0];
        v_we = 1'b1; v_wdata = VEL_RESET;
        l_we = 1'b1; l_wdata = LEN_RESET;
        k_we = 1'b1; k_wdata = 1'b0;
      end
      S_IDLE: begin
        t_raddr = 7'd0;
        s_raddr = {req.step_index, 2'd0};
        p_raddr = req.step_index;
        if (accept && req.cmd == CMD_PARAMS) begin
          p_waddr = req.step_index;
          v_we = 1'b1; v_wdata = req.step_velocity_in;
          l_we = 1'b1;
          l_wdata = (req.step_length_in == 4'd0) ? 4'd1 : req.step_length_in;
        end
        if (accept && req.cmd == CMD_LOCK) begin
          p_waddr = req.step_index; k_we = 1'b1; k_wdata = 1'b1;
        end
      end
      S_TRD: t_raddr = cnt[6:0];
      S_TWR: begin
        t_raddr = cnt[6:0] + 7'd1;
        s_raddr = {play_pos, 2'd0};
        p_raddr = play_pos;
        if (t_rdata != 4'd0) begin
          t_we = 1'b1; t_waddr = cnt[6:0]; t_wdata = t_dec;
          new_valid = (t_dec == 4'd0);
        end
      end
      S_SRD: begin
        s_raddr = {play_pos, slot};
        p_raddr = play_pos;
      end
      S_SNT: begin
        t_raddr = slot_note;
        p_raddr = play_pos;
        s_raddr = {play_pos, slot};
      end
      S_SWR: begin
        p_raddr = play_pos;
        s_raddr = {play_pos, slot};
        t_raddr = cur.note_number;
        t_we = 1'b1; t_waddr = cur.note_number; t_wdata = l_rdata;
        new_valid = 1'b1;
        new_evt.event_kind = (t_rdata != 4'd0) ? EV_RETR : EV_ON;
        new_evt.event_note = cur.note_number;
        new_evt.event_velocity = v_rdata;
      end
      S_ARD: s_raddr = {edit_step, slot};
      S_AEV: begin
        s_raddr = {edit_step, slot + 2'd1};
        if (k_rdata) begin
          // locked: first slot takes the note, the rest are swept clear
          s_we = 1'b1; s_waddr = {edit_step, 2'd0}; s_wdata = cur.note_number;
          k_we = 1'b1; k_wdata = 1'b0;
        end else if (slot_note != cur.note_number && slot_note == 7'd0) begin
          s_we = 1'b1; s_waddr = {edit_step, slot}; s_wdata = cur.note_number;
        end
      end
      S_CLR: begin
        s_we = 1'b1; s_waddr = {edit_step, slot}; s_wdata = 7'd0;
        k_we = (slot == 2'd3) && (cur.cmd == CMD_CLEAR);
        k_wdata = 1'b0;
      end
      S_LAST: ;
      default: ;
    endcase
  end

  // output: the held event goes out once the next one or the end is known
  always_ff @(posedge clk) begin
    if (rst) begin
      evt_valid <= 1'b0;
    end else begin
      evt_valid <= pend_valid && (new_valid || state == S_LAST);
    end
    evt <= '{event_kind: pend.event_kind, event_note: pend.event_note,
             event_velocity: pend.event_velocity, event_channel: pend.event_channel,
             last_event: (state == S_LAST)};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_INIT;
      cnt        <= '0;
      slot       <= '0;
      channel    <= '0;
      step_count <= STEPS_RESET;
      play_pos   <= '0;
      playing    <= 1'b0;
      pend_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_CHANNEL) channel <= cfg_data[3:0];
        else step_count <= cfg_data;
      end
      if (new_valid) begin
        pend_valid <= 1'b1;
        pend       <= new_evt;
      end
      unique case (state)
        S_INIT: begin
          cnt <= cnt + 8'd1;
          if (cnt == 8'hFF) state <= S_IDLE;
        end
        S_IDLE: begin
          pend_valid <= 1'b0;
          slot <= '0;
          cnt  <= '0;
          if (accept) begin
            cur <= req;
            unique case (req.cmd)
              CMD_TICK: if (req.on_boundary) state <= S_TRD;
              CMD_PLAY: begin
                if (!req.play_request || (!playing && req.on_boundary)) begin
                  if (req.play_request != playing) play_pos <= '0;
                  playing <= req.play_request;
                end
              end
              CMD_ADD:   state <= S_ARD;
              CMD_CLEAR: state <= S_CLR;
              default: ;
            endcase
          end
        end
        S_TRD: state <= S_TWR;
        S_TWR: begin
          cnt <= cnt + 8'd1;
          if (cnt[6:0] == 7'd127) begin
            state <= playing ? S_SRD : S_LAST;
            slot  <= '0;
          end else begin
            state <= S_TRD;
          end
        end
        S_SRD: state <= S_SNT;
        S_SNT: begin
          cur.note_number <= slot_note;
          if (slot_note != 7'd0) state <= S_SWR;
          else if (slot == 2'd3) state <= S_LAST;
          else begin
            slot  <= slot + 2'd1;
            state <= S_SRD;
          end
        end
        S_SWR: begin
          if (slot == 2'd3) state <= S_LAST;
          else begin
            slot  <= slot + 2'd1;
            state <= S_SRD;
          end
        end
        S_ARD: state <= S_AEV;
        S_AEV: begin
          if (k_rdata) begin
            slot  <= 2'd1;
            state <= S_CLR;
          end else if (slot_note == cur.note_number || slot_note == 7'd0
                       || slot == 2'd3) begin
            state <= S_IDLE;
          end else begin
            slot  <= slot + 2'd1;
            state <= S_ARD;
          end
        end
        S_CLR: begin
          slot <= slot + 2'd1;
          if (slot == 2'd3) state <= S_IDLE;
        end
        S_LAST: begin
          pend_valid <= 1'b0;
          state      <= S_IDLE;
          if (playing) begin
            // zero step count pins the playhead, above 64 never matches
            if ({1'b0, pos_inc} >= step_count)
              play_pos <= '0;
            else
              play_pos <= pos_inc;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // a result never appears unless the block was busy just before
  assert property (@(posedge clk) disable iff (rst)
    evt_valid |-> $past(busy)) else $error("event without work");
  // a last-marked event always appears while the block is idle
  assert property (@(posedge clk) disable iff (rst)
    (evt_valid && evt.last_event) |-> !busy) else $error("last event while busy");
  // requests are never taken during the clearing pass
  assert property (@(posedge clk) disable iff (rst)
    (state == S_INIT) |-> busy) else $error("init not busy");

endmodule
`default_nettype wire
